// ----- sv/slr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// slr_pkg: shape list rasterizer package
// Types, codes and sizes shared by the controller, datapath, top level and checker.
// ----------------------------------------------------------------------------
package slr_pkg;

	localparam int MAX_SHAPES = 16;
	localparam int MAX_DIM    = 256;
	localparam int IDX_W      = $clog2(MAX_SHAPES);
	localparam int CNT_W      = $clog2(MAX_SHAPES + 1);
	localparam int DIM_W      = $clog2(MAX_DIM + 1);
	localparam int CFG_IDX_W  = 1;

	localparam logic [7:0]       BLANK_PIXEL   = 8'd46;
	localparam logic [DIM_W-1:0] CANVAS_RESET  = DIM_W'(16);
	localparam logic [DIM_W-1:0] CANVAS_MAX    = DIM_W'(MAX_DIM);
	localparam logic [CNT_W-1:0] SHAPES_FULL   = CNT_W'(MAX_SHAPES);

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_DEL   = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_RECT     = 2'd0,
		KIND_TRI_UP   = 2'd1,
		KIND_TRI_DOWN = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_SIZE   = 3'd1,
		ST_OFF_CANVAS = 3'd2,
		ST_FULL       = 3'd3,
		ST_NO_ENTRY   = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROWS = 1'b0,
		CFG_COLS = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [1:0] shape_kind;
		logic [7:0] centre_x;
		logic [7:0] centre_y;
		logic [7:0] shape_width;
		logic [7:0] shape_height;
		logic [7:0] brush_char;
		logic [3:0] entry_index;
		logic [7:0] query_row;
		logic [7:0] query_col;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] w;
		logic [7:0] h;
		logic [7:0] brush;
	} shape_t;

	typedef struct packed {
		logic load;
		logic check;
		logic scan_en;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_scan;
		logic scan_done;
	} dp_stat_t;

endpackage
`default_nettype wire

// ----- sv/slr_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// slr_if: shape list rasterizer channels
// Command channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface slr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [1:0] shape_kind;
	logic [7:0] centre_x;
	logic [7:0] centre_y;
	logic [7:0] shape_width;
	logic [7:0] shape_height;
	logic [7:0] brush_char;
	logic [3:0] entry_index;
	logic [7:0] query_row;
	logic [7:0] query_col;

	modport source (output valid, cmd, shape_kind, centre_x, centre_y, shape_width,
		shape_height, brush_char, entry_index, query_row, query_col, input ready);
	modport sink (input valid, cmd, shape_kind, centre_x, centre_y, shape_width,
		shape_height, brush_char, entry_index, query_row, query_col, output ready);
endinterface

interface slr_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [3:0] new_index;
	logic [7:0] pixel_char;

	modport source (output valid, status, new_index, pixel_char, input ready);
	modport sink (input valid, status, new_index, pixel_char, output ready);
endinterface
`default_nettype wire

// ----- sv/slr_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// slr_ctrl: shape list rasterizer controller
// Sequences accept, check, table walk and result hand-off.
// ----------------------------------------------------------------------------
module slr_ctrl import slr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire dp_stat_t  stat,
	output ctrl_cmd_t      ctl
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				ctl.check = 1'b1;
				state_d   = stat.need_scan ? S_SCAN : S_FINISH;
			end
			S_SCAN: begin
				ctl.scan_en = 1'b1;
				if (stat.scan_done)
					state_d = S_FINISH;
			end
			S_FINISH: begin
				// The result register frees up in the same cycle it is taken.
				if (!out_valid_q || out_ready) begin
					ctl.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ----- sv/slr_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// slr_dp: shape list rasterizer datapath
// Canvas registers, shape table memory, add checks, coverage test and results.
// ----------------------------------------------------------------------------
module slr_dp import slr_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data,
	input  wire item_t                item,
	input  wire ctrl_cmd_t            ctl,
	output dp_stat_t                  stat,
	output logic [2:0]                status,
	output logic [3:0]                new_index,
	output logic [7:0]                pixel_char
);

	item_t            item_q;
	logic [DIM_W-1:0] rows_q, cols_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] ptr_q;
	shape_t           mem [MAX_SHAPES];
	shape_t           rd_data_s1;
	logic [IDX_W-1:0] rd_addr_s1;
	logic             rd_valid_s1;

	status_t          res_status_q;
	logic [3:0]       res_new_q;
	logic [7:0]       res_pix_q;
	logic [2:0]       out_status_q;
	logic [3:0]       out_new_q;
	logic [7:0]       out_pix_q;

	logic [DIM_W-1:0] cfg_sat;
	assign cfg_sat = (cfg_data > CANVAS_MAX) ? CANVAS_MAX : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CANVAS_RESET;
			cols_q <= CANVAS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_ROWS: rows_q <= cfg_sat;
				CFG_COLS: cols_q <= cfg_sat;
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load)
			item_q <= item;
	end

	// Extent of the shape around its centre or apex, then the canvas bounds.
	logic [7:0] left, right, top, bottom, ext;
	logic       size_bad, off_canvas;
	status_t    add_status;

	always_comb begin
		left     = '0;
		right    = '0;
		top      = '0;
		bottom   = '0;
		size_bad = 1'b0;
		ext      = (item_q.shape_height == 8'd0) ? 8'd0 : item_q.shape_height - 8'd1;
		case (item_q.shape_kind)
			KIND_RECT: begin
				size_bad = !item_q.shape_width[0] || !item_q.shape_height[0];
				left     = item_q.shape_width >> 1;
				right    = item_q.shape_width >> 1;
				top      = item_q.shape_height >> 1;
				bottom   = item_q.shape_height >> 1;
			end
			KIND_TRI_UP: begin
				left   = ext;
				right  = ext;
				bottom = ext;
			end
			KIND_TRI_DOWN: begin
				left  = ext;
				right = ext;
				top   = ext;
			end
			default: size_bad = 1'b1;
		endcase
		off_canvas = (item_q.centre_x < left) || (item_q.centre_y < top) ||
			(({1'b0, item_q.centre_x} + {1'b0, right}) >= cols_q) ||
			(({1'b0, item_q.centre_y} + {1'b0, bottom}) >= rows_q);
		if (size_bad)
			add_status = ST_BAD_SIZE;
		else if (off_canvas)
			add_status = ST_OFF_CANVAS;
		else if (count_q >= SHAPES_FULL)
			add_status = ST_FULL;
		else
			add_status = ST_OK;
	end

	logic del_ok, query_on;
	assign del_ok   = CNT_W'(item_q.entry_index) < count_q;
	assign query_on = ({1'b0, item_q.query_row} < rows_q) &&
		({1'b0, item_q.query_col} < cols_q);

	// Table walk: read one entry per cycle, use the registered data in the next cycle.
	logic issue;
	assign issue = ctl.scan_en && (ptr_q < count_q);

	always_comb begin
		stat.need_scan = ((item_q.cmd == CMD_DEL) && del_ok) ||
			((item_q.cmd == CMD_QUERY) && query_on);
		stat.scan_done = ctl.scan_en && !issue && !rd_valid_s1;
	end

	// Coverage of the queried pixel by the entry just read.
	logic [7:0] dx, dy, k;
	logic       k_ok, hit;

	always_comb begin
		dx   = (item_q.query_col >= rd_data_s1.x) ? item_q.query_col - rd_data_s1.x :
			rd_data_s1.x - item_q.query_col;
		dy   = (item_q.query_row >= rd_data_s1.y) ? item_q.query_row - rd_data_s1.y :
			rd_data_s1.y - item_q.query_row;
		k    = dy;
		k_ok = 1'b0;
		hit  = 1'b0;
		case (rd_data_s1.kind)
			KIND_RECT:
				hit = (dx <= (rd_data_s1.w >> 1)) && (dy <= (rd_data_s1.h >> 1));
			KIND_TRI_UP: begin
				k_ok = item_q.query_row >= rd_data_s1.y;
				hit  = k_ok && (k < rd_data_s1.h) && (dx <= k);
			end
			KIND_TRI_DOWN: begin
				k_ok = rd_data_s1.y >= item_q.query_row;
				hit  = k_ok && (k < rd_data_s1.h) && (dx <= k);
			end
			default: hit = 1'b0;
		endcase
	end

	// Single write port: an add in the check cycle, or a shift during delete.
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	shape_t           wr_data;
	logic             add_commit;

	assign add_commit = ctl.check && (item_q.cmd == CMD_ADD) && (add_status == ST_OK);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[IDX_W-1:0];
		wr_data = '{kind: item_q.shape_kind, x: item_q.centre_x, y: item_q.centre_y,
			w: item_q.shape_width, h: item_q.shape_height, brush: item_q.brush_char};
		if (add_commit) begin
			wr_en = 1'b1;
		end else if (rd_valid_s1 && (item_q.cmd == CMD_DEL)) begin
			wr_en   = 1'b1;
			wr_addr = rd_addr_s1 - IDX_W'(1);
			wr_data = rd_data_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (issue) begin
			rd_data_s1 <= mem[ptr_q[IDX_W-1:0]];
			rd_addr_s1 <= ptr_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ptr_q       <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			if (ctl.check)
				ptr_q <= (item_q.cmd == CMD_DEL) ?
					CNT_W'(item_q.entry_index) + CNT_W'(1) : '0;
			else if (issue)
				ptr_q <= ptr_q + CNT_W'(1);
			if (add_commit)
				count_q <= count_q + CNT_W'(1);
			else if (stat.scan_done && (item_q.cmd == CMD_DEL))
				count_q <= count_q - CNT_W'(1);
		end
	end

	// Result fields known in the check cycle; a query walk may still repaint the pixel.
	status_t    chk_status;
	logic [3:0] chk_new;
	logic [7:0] chk_pix;

	always_comb begin
		chk_status = ST_OK;
		chk_new    = 4'd0;
		chk_pix    = 8'd0;
		case (item_q.cmd)
			CMD_ADD: begin
				chk_status = add_status;
				if (add_status == ST_OK)
					chk_new = 4'(count_q);
			end
			CMD_DEL:
				if (!del_ok)
					chk_status = ST_NO_ENTRY;
			CMD_QUERY: begin
				chk_pix = BLANK_PIXEL;
				if (!query_on)
					chk_status = ST_OFF_CANVAS;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.check) begin
			res_status_q <= chk_status;
			res_new_q    <= chk_new;
			res_pix_q    <= chk_pix;
		end else if (rd_valid_s1 && (item_q.cmd == CMD_QUERY) && hit) begin
			// Later entries overwrite earlier ones, so the last cover wins.
			res_pix_q <= rd_data_s1.brush;
		end
		if (ctl.load_out) begin
			out_status_q <= res_status_q;
			out_new_q    <= res_new_q;
			out_pix_q    <= res_pix_q;
		end
	end

	assign status     = out_status_q;
	assign new_index  = out_new_q;
	assign pixel_char = out_pix_q;

endmodule
`default_nettype wire

// ----- sv/shape_list_rasterizer.sv -----
`default_nettype none
// Sequence: after acceptance a command is checked; an add, a rejected delete, an
// off-canvas query or an unknown command then goes straight to the result register; a delete
// or query walks the table one entry per cycle over a single read port (at most 16 entries).
// Handshake: one command at a time; the next is taken in the cycle after the result is
// registered, and later while an earlier result waits.
// Reset: shape count cleared, canvas 16 x 16; table contents stay undefined until written.
// ----------------------------------------------------------------------------
// shape_list_rasterizer: shape list with pixel queries
// Controller and datapath joined by command and status structs.
// ----------------------------------------------------------------------------
module shape_list_rasterizer import slr_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data,
	slr_in_if.sink                    in_ch,
	slr_out_if.source                 out_ch
);

	ctrl_cmd_t ctl;
	dp_stat_t  stat;
	item_t     item;

	assign item = '{cmd: in_ch.cmd, shape_kind: in_ch.shape_kind,
		centre_x: in_ch.centre_x, centre_y: in_ch.centre_y,
		shape_width: in_ch.shape_width, shape_height: in_ch.shape_height,
		brush_char: in_ch.brush_char, entry_index: in_ch.entry_index,
		query_row: in_ch.query_row, query_col: in_ch.query_col};

	slr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	slr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item       (item),
		.ctl        (ctl),
		.stat       (stat),
		.status     (out_ch.status),
		.new_index  (out_ch.new_index),
		.pixel_char (out_ch.pixel_char)
	);

endmodule
`default_nettype wire

// ----- sv/slr_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// slr_checker: shape list rasterizer port checks
// Watches the result channel for handshake and result consistency.
// ----------------------------------------------------------------------------
module slr_checker import slr_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] status,
	input wire logic [3:0] new_index,
	input wire logic [7:0] pixel_char
);

	// A stalled result transaction stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= ST_NO_ENTRY))
		else $error("undefined status code");

	// Only a successful add reports a nonzero list position.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (new_index != 4'd0) |-> (status == ST_OK) && (pixel_char == 8'd0))
		else $error("new index on a result that is not an add");

	// A failed delete, or an add rejected as full or bad size, reports no pixel and no position.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((status == ST_NO_ENTRY) || (status == ST_FULL) ||
		(status == ST_BAD_SIZE)) |-> (pixel_char == 8'd0) && (new_index == 4'd0))
		else $error("stray payload on a rejected command");

endmodule

bind shape_list_rasterizer slr_checker u_slr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.status     (out_ch.status),
	.new_index  (out_ch.new_index),
	.pixel_char (out_ch.pixel_char)
);
`default_nettype wire
